// File: hdl/bfpsb_pkg.sv
// Shared types, codes and symbol decoder for the program store block.
package bfpsb_pkg;

    localparam int POS_W   = 12;   // position field
    localparam int TGT_W   = 12;   // target field
    localparam int CNT_W   = 13;   // count / extent / length fields
    localparam int SYM_W   = 8;
    localparam int CODE_W  = 3;
    localparam int NUM_CODES = 8;

    // Request commands
    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_JUMP   = 2'd1,
        CMD_COUNT  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    // Result status
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_IGNORED   = 3'd1,
        ST_UNMATCHED = 3'd2,
        ST_NOT_BR    = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // Stored command codes
    localparam logic [CODE_W-1:0] CODE_PLUS  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_MINUS = 3'd1;
    localparam logic [CODE_W-1:0] CODE_LEFT  = 3'd2;
    localparam logic [CODE_W-1:0] CODE_RIGHT = 3'd3;
    localparam logic [CODE_W-1:0] CODE_OUT   = 3'd4;
    localparam logic [CODE_W-1:0] CODE_IN    = 3'd5;
    localparam logic [CODE_W-1:0] CODE_OPEN  = 3'd6;
    localparam logic [CODE_W-1:0] CODE_CLOSE = 3'd7;

    // ASCII characters
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_LEFT  = 8'h3C;
    localparam logic [SYM_W-1:0] CH_RIGHT = 8'h3E;
    localparam logic [SYM_W-1:0] CH_OUT   = 8'h2E;
    localparam logic [SYM_W-1:0] CH_IN    = 8'h2C;
    localparam logic [SYM_W-1:0] CH_OPEN  = 8'h5B;
    localparam logic [SYM_W-1:0] CH_CLOSE = 8'h5D;

    typedef struct packed {
        logic                valid;
        logic [CODE_W-1:0]   code;
    } t_sym;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_CLASS,
        SC_FWD,
        SC_BWD
    } t_scan_state;

    typedef enum logic {
        TS_IDLE,
        TS_JUMP
    } t_top_state;

    typedef struct packed {
        logic    done;
        t_status status;
    } t_scan_res;

    function automatic t_sym sym_decode(input logic [SYM_W-1:0] s);
        t_sym r;
        r.valid = 1'b1;
        case (s)
            CH_PLUS:  r.code = CODE_PLUS;
            CH_MINUS: r.code = CODE_MINUS;
            CH_LEFT:  r.code = CODE_LEFT;
            CH_RIGHT: r.code = CODE_RIGHT;
            CH_OUT:   r.code = CODE_OUT;
            CH_IN:    r.code = CODE_IN;
            CH_OPEN:  r.code = CODE_OPEN;
            CH_CLOSE: r.code = CODE_CLOSE;
            default: begin
                r.valid = 1'b0;
                r.code  = CODE_PLUS;
            end
        endcase
        return r;
    endfunction

endpackage

// File: hdl/bfpsb_prog_mem.sv
// Program memory: one write port, one registered read port.
module bfpsb_prog_mem
    import bfpsb_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [CODE_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [CODE_W-1:0] o_rdata
);

    logic [CODE_W-1:0] mem [DEPTH];
    logic [CODE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/bfpsb_scan_unit.sv
// Bracket scan sequencer: one program entry per cycle with a nesting counter.
module bfpsb_scan_unit
    import bfpsb_pkg::*;
#(
    parameter int AW = 12,
    parameter int LW = 13
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [AW-1:0]     i_pos,
    input  logic [LW-1:0]     i_len,
    input  logic [CODE_W-1:0] i_rdata,
    output logic [AW-1:0]     o_raddr,
    output t_scan_res         o_res,
    output logic [AW-1:0]     o_target
);

    localparam int DW = LW + 1;   // signed nesting depth

    t_scan_state r_state, n_state;
    logic [AW-1:0]        r_idx, n_idx;
    logic signed [DW-1:0] r_depth, n_depth;

    // step datapath
    logic                 fwd;
    logic                 is_br;
    logic signed [DW-1:0] delta;
    logic signed [DW-1:0] depth_step;
    logic [AW-1:0]        adv_idx;
    logic                 at_end;
    logic                 finish;
    t_status              fin_status;

    always_comb begin
        fwd   = (r_state == SC_CLASS) ? (i_rdata == CODE_OPEN) : (r_state == SC_FWD);
        is_br = (r_state != SC_CLASS) || (i_rdata == CODE_OPEN) || (i_rdata == CODE_CLOSE);
        delta = '0;
        if (i_rdata == CODE_OPEN) begin
            delta = fwd ? DW'(1) : -DW'(1);
        end else if (i_rdata == CODE_CLOSE) begin
            delta = fwd ? -DW'(1) : DW'(1);
        end
        depth_step = r_depth + delta;
        adv_idx    = fwd ? (r_idx + AW'(1)) : (r_idx - AW'(1));
        at_end     = fwd ? ((LW'(r_idx) + LW'(1)) >= i_len) : (r_idx == '0);
        finish     = 1'b1;
        fin_status = ST_OK;
        if (!is_br) begin
            fin_status = ST_NOT_BR;
        end else if (depth_step == '0) begin
            fin_status = ST_OK;
        end else if (at_end) begin
            fin_status = ST_UNMATCHED;
        end else begin
            finish = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SC_IDLE: begin
                if (i_go) n_state = SC_CLASS;
            end
            SC_CLASS, SC_FWD, SC_BWD: begin
                if (finish)   n_state = SC_IDLE;
                else if (fwd) n_state = SC_FWD;
                else          n_state = SC_BWD;
            end
            default: n_state = SC_IDLE;
        endcase
    end

    // outputs and datapath next values
    always_comb begin
        o_raddr      = (r_state == SC_IDLE) ? i_pos : adv_idx;
        o_res.done   = (r_state != SC_IDLE) && finish;
        o_res.status = fin_status;
        o_target     = r_idx;
        n_idx        = r_idx;
        n_depth      = r_depth;
        if (r_state == SC_IDLE) begin
            if (i_go) begin
                n_idx   = i_pos;
                n_depth = '0;
            end
        end else if (!finish) begin
            n_idx   = adv_idx;
            n_depth = depth_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_depth <= n_depth;
    end

endmodule

// File: hdl/bf_program_store_bracket_match_unit.sv
// Top level of the program store with bracket matching.
//
// Usage: a request is taken at a rising edge where start is high and busy
// is low. The request carries i_command (append, jump query, count query,
// clear), i_symbol and i_position. Exactly one result follows per request:
// o_valid is high for one cycle with o_status, o_target, o_op_count,
// o_tape_extent and o_prog_length. The receiver cannot stall, so results
// are never held back.
// Append, count and clear answer in the cycle after the request
// and busy stays low, so one such request can be taken every cycle.
// A jump query walks the program memory one entry per cycle from the
// bracket toward its partner; its result is registered once the walk
// finds the partner, reaches the end of the program or finds no
// bracket at the position; busy is high for that whole walk. A jump
// at a position at or past the program length answers in the next cycle.
// Reset clears the length, the symbol counters, the tape extent and sets
// the tape pointer to one; memory contents are not cleared (entries past
// the length are never used).
module bf_program_store_bracket_match_unit
    import bfpsb_pkg::*;
#(
    parameter int PROG_DEPTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_command,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic [POS_W-1:0]  i_position,
    output logic              o_valid,
    output logic [2:0]        o_status,
    output logic [TGT_W-1:0]  o_target,
    output logic [CNT_W-1:0]  o_op_count,
    output logic [CNT_W-1:0]  o_tape_extent,
    output logic [CNT_W-1:0]  o_prog_length
);

    localparam int AW = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;  // memory index
    localparam int LW = $clog2(PROG_DEPTH + 1);                      // length / counts
    localparam int MW = LW + 1;                                      // tape max
    localparam int TW = LW + 2;                                      // signed pointer
    localparam int PW = (LW > POS_W) ? LW : POS_W;                   // position compare

    t_top_state r_state, n_state;

    // program state
    logic [LW-1:0]        r_len, n_len;
    logic [LW-1:0]        r_cnt [NUM_CODES];
    logic [LW-1:0]        n_cnt [NUM_CODES];
    logic signed [TW-1:0] r_ptr, n_ptr;
    logic [MW-1:0]        r_max, n_max;

    // result registers
    logic                 r_valid, n_valid;
    t_status              r_status, n_status;
    logic [TGT_W-1:0]     r_target, n_target;
    logic [CNT_W-1:0]     r_op_count, n_op_count;
    logic [CNT_W-1:0]     r_extent, n_extent;
    logic [CNT_W-1:0]     r_length, n_length;

    // request decode
    logic                 accept;
    t_cmd                 cmd;
    t_sym                 sym;
    logic                 pos_ok;
    logic                 full;
    logic                 wr_en;
    logic                 go;
    logic signed [TW-1:0] ptr_new;

    // scan / memory links
    logic [CODE_W-1:0]    mem_rdata;
    logic [AW-1:0]        mem_raddr;
    t_scan_res            scan_res;
    logic [AW-1:0]        scan_target;

    always_comb begin
        accept  = start && !busy;
        cmd     = t_cmd'(i_command);
        sym     = sym_decode(i_symbol);
        pos_ok  = PW'(i_position) < PW'(r_len);
        full    = r_len >= LW'(PROG_DEPTH);
        wr_en   = accept && (cmd == CMD_APPEND) && sym.valid && !full;
        go      = accept && (cmd == CMD_JUMP) && pos_ok;
        ptr_new = r_ptr;
        if (sym.code == CODE_RIGHT) begin
            ptr_new = r_ptr + TW'(1);
        end else if (sym.code == CODE_LEFT) begin
            ptr_new = r_ptr - TW'(1);
        end
    end

    bfpsb_prog_mem #(
        .DEPTH (PROG_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (sym.code),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bfpsb_scan_unit #(
        .AW (AW),
        .LW (LW)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_pos    (AW'(i_position)),
        .i_len    (r_len),
        .i_rdata  (mem_rdata),
        .o_raddr  (mem_raddr),
        .o_res    (scan_res),
        .o_target (scan_target)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            TS_IDLE: begin
                if (go) n_state = TS_JUMP;
            end
            TS_JUMP: begin
                if (scan_res.done) n_state = TS_IDLE;
            end
            default: n_state = TS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        busy          = (r_state == TS_JUMP);
        o_valid       = r_valid;
        o_status      = r_status;
        o_target      = r_target;
        o_op_count    = r_op_count;
        o_tape_extent = r_extent;
        o_prog_length = r_length;
    end

    // program state and result datapath
    always_comb begin
        n_len = r_len;
        n_ptr = r_ptr;
        n_max = r_max;
        for (int k = 0; k < NUM_CODES; k++) begin
            n_cnt[k] = r_cnt[k];
        end

        if (wr_en) begin
            n_len = r_len + LW'(1);
            n_ptr = ptr_new;
            if (ptr_new > $signed({1'b0, r_max})) begin
                n_max = ptr_new[MW-1:0];
            end
            for (int k = 0; k < NUM_CODES; k++) begin
                if (sym.code == CODE_W'(k)) n_cnt[k] = r_cnt[k] + LW'(1);
            end
        end else if (accept && (cmd == CMD_CLEAR)) begin
            n_len = '0;
            n_ptr = TW'(1);
            n_max = '0;
            for (int k = 0; k < NUM_CODES; k++) begin
                n_cnt[k] = '0;
            end
        end

        n_valid    = (accept && !go) || (busy && scan_res.done);
        n_status   = ST_OK;
        n_target   = '0;
        n_op_count = '0;
        n_extent   = CNT_W'(n_max);
        n_length   = CNT_W'(n_len);

        if (busy) begin
            n_status = scan_res.status;
            if (scan_res.status == ST_OK) n_target = TGT_W'(scan_target);
        end else begin
            case (cmd)
                CMD_APPEND: begin
                    if (!sym.valid) n_status = ST_IGNORED;
                    else if (full)  n_status = ST_FULL;
                    else            n_status = ST_OK;
                end
                CMD_JUMP: begin
                    n_status = ST_NOT_BR;   // position past the program
                end
                CMD_COUNT: begin
                    if (sym.valid) n_op_count = CNT_W'(r_cnt[sym.code]);
                end
                CMD_CLEAR: begin
                    n_status = ST_OK;
                end
                default: n_status = ST_OK;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TS_IDLE;
            r_valid <= 1'b0;
            r_len   <= '0;
            r_ptr   <= TW'(1);
            r_max   <= '0;
            for (int k = 0; k < NUM_CODES; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_len   <= n_len;
            r_ptr   <= n_ptr;
            r_max   <= n_max;
            for (int k = 0; k < NUM_CODES; k++) begin
                r_cnt[k] <= n_cnt[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_target   <= n_target;
        r_op_count <= n_op_count;
        r_extent   <= n_extent;
        r_length   <= n_length;
    end

endmodule
